// File: sv/assert_macros.svh
// Assertion macros for the grid interpolator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted
`define BGI_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("grid interpolator check failed");

// Next-cycle implication, ignored while reset is asserted
`define BGI_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("grid interpolator check failed");

`endif

// File: sv/bgi_pkg.sv
// Types, constants and codes of the bilinear grid interpolator
package bgi_pkg;

  localparam int MAX_V_POINTS_DEF = 16;
  localparam int MAX_A_POINTS_DEF = 16;

  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int AXIS_W    = 16;
  localparam int CELL_W    = 32;
  localparam int FRAC_W    = 17;

  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] CFG_V_POINTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_POINTS = 1'b1;

  typedef enum logic [1:0] {
    KIND_LOOKUP   = 2'd0,
    KIND_WR_VAXIS = 2'd1,
    KIND_WR_AAXIS = 2'd2,
    KIND_WR_CELL  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic [3:0]               row;
    logic [3:0]               col;
    logic signed [AXIS_W-1:0] axis_value;
    logic signed [CELL_W-1:0] cell_value;
    logic signed [AXIS_W-1:0] v_query;
    logic signed [AXIS_W-1:0] a_query;
  } req_t;

  typedef struct packed {
    logic signed [CELL_W-1:0] command;
    logic                     grid_empty;
  } res_t;

  typedef struct packed {
    logic              start;
    logic [AXIS_W-1:0] num;
    logic [AXIS_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quot;
  } div_rsp_t;

endpackage

// File: sv/bilinear_grid_interpolator.sv
// Top level of the bilinear grid interpolator: grid memories, axis search and interpolation
//
// Writes to the velocity axis, acceleration axis or command table take effect at the
// accepting edge and leave busy_o low, so one write item can be taken every cycle while
// busy_o is low. A lookup on an empty grid also leaves busy_o low and shows its result in
// the next cycle. Any other lookup holds busy_o high while it runs: per axis, a one-point
// axis ends in S_AX0, else the first point is read and ends the search when the query is
// at or below it, else the last point is read and ends it when the query is at or above
// it, else the scan reads one axis point a cycle from the axis memory, and the serial
// fraction divider runs when the query falls inside a span of non-zero width; then states
// S_C0 to S_C7 read four cells, one a cycle from the cell memory, and run the three
// interpolation steps on one shared multiplier. Each result is on res_o for exactly one
// cycle with done_o high, for a busy lookup in the cycle that busy_o falls; the receiver
// cannot stall. A new item may be started in the cycle that a result is shown. Memories
// are not cleared: read an axis point or cell only after writing it. Point counts are
// written through the cfg port and saturate at the axis depth; the user must write them
// only while the block is idle, which the block itself does not enforce.
module bilinear_grid_interpolator #(
  parameter int MAX_V_POINTS = bgi_pkg::MAX_V_POINTS_DEF,
  parameter int MAX_A_POINTS = bgi_pkg::MAX_A_POINTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  bgi_pkg::req_t                  req_i,
  output logic                           busy_o,
  output logic                           done_o,
  output bgi_pkg::res_t                  res_o,
  input  logic                           cfg_we_i,
  input  logic [bgi_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bgi_pkg::CNT_W-1:0]      cfg_wdata_i
);
  import bgi_pkg::*;

  localparam int VIW        = $clog2(MAX_V_POINTS);
  localparam int AIW        = $clog2(MAX_A_POINTS);
  localparam int IW         = (VIW > AIW) ? VIW : AIW;
  localparam int AX_DEPTH   = MAX_V_POINTS + MAX_A_POINTS;
  localparam int AXW        = $clog2(AX_DEPTH);
  localparam int CELL_DEPTH = MAX_V_POINTS * MAX_A_POINTS;
  localparam int CW         = $clog2(CELL_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_AX0  = 4'd1;
  localparam logic [3:0] S_AXL  = 4'd2;
  localparam logic [3:0] S_AXH  = 4'd3;
  localparam logic [3:0] S_SCAN = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_C0   = 4'd6;
  localparam logic [3:0] S_C1   = 4'd7;
  localparam logic [3:0] S_C2   = 4'd8;
  localparam logic [3:0] S_C3   = 4'd9;
  localparam logic [3:0] S_C4   = 4'd10;
  localparam logic [3:0] S_C5   = 4'd11;
  localparam logic [3:0] S_C6   = 4'd12;
  localparam logic [3:0] S_C7   = 4'd13;

  // Configuration
  logic [CNT_W-1:0] v_pts_q;
  logic [CNT_W-1:0] a_pts_q;

  // Control
  logic [3:0]  state_q, state_d;
  logic        sel_q, sel_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic        done_q, done_d;

  // Payload
  logic signed [AXIS_W-1:0] vq_q, vq_d;
  logic signed [AXIS_W-1:0] aq_q, aq_d;
  logic signed [AXIS_W-1:0] lo_q, lo_d;
  logic [IW-1:0]            vidx_q, vidx_d;
  logic [IW-1:0]            aidx_q, aidx_d;
  logic [FRAC_W-1:0]        vfrac_q, vfrac_d;
  logic [FRAC_W-1:0]        afrac_q, afrac_d;
  logic signed [CELL_W-1:0] clo_q, clo_d;
  logic signed [CELL_W-1:0] c0_q, c0_d;
  logic signed [CELL_W+FRAC_W+1:0] prod_q, prod_d;
  res_t                     res_q, res_d;

  // Memories
  logic signed [AXIS_W-1:0] ax_mem [AX_DEPTH];
  logic signed [AXIS_W-1:0] ax_rdata_q;
  logic signed [CELL_W-1:0] cell_mem [CELL_DEPTH];
  logic signed [CELL_W-1:0] cell_rdata_q;

  logic             accept;
  logic             grid_empty;
  logic             ax_we;
  logic [AXW-1:0]   ax_waddr;
  logic [AXW-1:0]   ax_raddr;
  logic [IW-1:0]    rd_off;
  logic             cell_we;
  logic [CW-1:0]    cell_waddr;
  logic [CW-1:0]    cell_raddr;
  logic [IW-1:0]    cvi;
  logic [IW-1:0]    cai;
  logic [IW-1:0]    v_nm1;
  logic [IW-1:0]    a_nm1;
  logic [IW-1:0]    nm1;
  logic             multi;
  logic [IW-1:0]    vi1;
  logic [IW-1:0]    ai1;
  logic signed [AXIS_W-1:0] x;
  logic [AXIS_W:0]  span_w;
  logic [AXIS_W:0]  num_w;
  logic             hit;
  logic             fin;
  logic [IW-1:0]    fin_idx;
  logic [FRAC_W-1:0] fin_frac;
  logic [CELL_W:0]  mul_diff;
  logic [FRAC_W-1:0] mul_frac;
  logic [CELL_W-1:0] step_w;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign busy_o     = state_q != S_IDLE;
  assign accept     = start_i && !busy_o;
  assign grid_empty = (v_pts_q == '0) || (a_pts_q == '0);

  // Point counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_pts_q <= '0;
      a_pts_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_V_POINTS) begin
        v_pts_q <= (32'(cfg_wdata_i) > MAX_V_POINTS) ? CNT_W'(MAX_V_POINTS) : cfg_wdata_i;
      end else if (cfg_idx_i == CFG_A_POINTS) begin
        a_pts_q <= (32'(cfg_wdata_i) > MAX_A_POINTS) ? CNT_W'(MAX_A_POINTS) : cfg_wdata_i;
      end
    end
  end

  // Axis memory: velocity points first, acceleration points after them
  assign ax_we = accept &&
                 ((req_i.kind == KIND_WR_VAXIS && 32'(req_i.row) < MAX_V_POINTS) ||
                  (req_i.kind == KIND_WR_AAXIS && 32'(req_i.col) < MAX_A_POINTS));
  assign ax_waddr = (req_i.kind == KIND_WR_VAXIS) ?
                    AXW'(32'(req_i.row)) : AXW'(MAX_V_POINTS + 32'(req_i.col));
  assign ax_raddr = AXW'((sel_q ? MAX_V_POINTS : 0) + 32'(rd_off));

  always_ff @(posedge clk_i) begin
    if (ax_we) begin
      ax_mem[ax_waddr] <= req_i.axis_value;
    end
    ax_rdata_q <= ax_mem[ax_raddr];
  end

  // Cell memory, row-major by velocity index
  assign cell_we = accept && req_i.kind == KIND_WR_CELL &&
                   32'(req_i.row) < MAX_V_POINTS && 32'(req_i.col) < MAX_A_POINTS;
  assign cell_waddr = CW'(32'(req_i.row) * MAX_A_POINTS + 32'(req_i.col));
  assign cell_raddr = CW'(32'(cvi) * MAX_A_POINTS + 32'(cai));

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= req_i.cell_value;
    end
    cell_rdata_q <= cell_mem[cell_raddr];
  end

  // Axis under search
  assign v_nm1  = IW'(v_pts_q - 1'b1);
  assign a_nm1  = IW'(a_pts_q - 1'b1);
  assign nm1    = sel_q ? a_nm1 : v_nm1;
  assign multi  = sel_q ? (a_pts_q > CNT_W'(1)) : (v_pts_q > CNT_W'(1));
  assign x      = sel_q ? aq_q : vq_q;
  assign span_w = {ax_rdata_q[AXIS_W-1], ax_rdata_q} - {lo_q[AXIS_W-1], lo_q};
  assign num_w  = {x[AXIS_W-1], x} - {lo_q[AXIS_W-1], lo_q};
  assign hit    = (x >= lo_q) && (x <= ax_rdata_q);
  assign vi1    = (v_pts_q > CNT_W'(1)) ? vidx_q + 1'b1 : vidx_q;
  assign ai1    = (a_pts_q > CNT_W'(1)) ? aidx_q + 1'b1 : aidx_q;

  // Floor of the product over 65536
  assign step_w = prod_q[CELL_W+15:16];

  always_comb begin
    state_d  = state_q;
    sel_d    = sel_q;
    ptr_d    = ptr_q;
    done_d   = 1'b0;
    vq_d     = vq_q;
    aq_d     = aq_q;
    lo_d     = lo_q;
    vidx_d   = vidx_q;
    aidx_d   = aidx_q;
    vfrac_d  = vfrac_q;
    afrac_d  = afrac_q;
    clo_d    = clo_q;
    c0_d     = c0_q;
    res_d    = res_q;
    rd_off   = '0;
    cvi      = vidx_q;
    cai      = aidx_q;
    fin      = 1'b0;
    fin_idx  = '0;
    fin_frac = '0;
    mul_diff = '0;
    mul_frac = '0;
    div_req.start = 1'b0;
    div_req.num   = num_w[AXIS_W-1:0];
    div_req.den   = span_w[AXIS_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept && req_i.kind == KIND_LOOKUP) begin
          vq_d = req_i.v_query;
          aq_d = req_i.a_query;
          if (grid_empty) begin
            done_d           = 1'b1;
            res_d.command    = '0;
            res_d.grid_empty = 1'b1;
          end else begin
            sel_d   = 1'b0;
            state_d = S_AX0;
          end
        end
      end
      S_AX0: begin
        if (!multi) begin
          fin = 1'b1;
        end else begin
          state_d = S_AXL;
        end
      end
      S_AXL: begin
        lo_d = ax_rdata_q;
        if (x <= ax_rdata_q) begin
          fin = 1'b1;
        end else begin
          rd_off  = nm1;
          state_d = S_AXH;
        end
      end
      S_AXH: begin
        if (x >= ax_rdata_q) begin
          fin      = 1'b1;
          fin_idx  = nm1 - 1'b1;
          fin_frac = FRAC_ONE;
        end else begin
          rd_off  = IW'(1);
          ptr_d   = IW'(1);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (span_w == '0) begin
            fin     = 1'b1;
            fin_idx = ptr_q - 1'b1;
          end else begin
            div_req.start = 1'b1;
            state_d       = S_DIV;
          end
        end else if (ptr_q == nm1) begin
          // No bracketing span on a non-ascending axis
          fin      = 1'b1;
          fin_idx  = nm1 - 1'b1;
          fin_frac = FRAC_ONE;
        end else begin
          lo_d   = ax_rdata_q;
          ptr_d  = ptr_q + 1'b1;
          rd_off = ptr_q + 1'b1;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          fin      = 1'b1;
          fin_idx  = ptr_q - 1'b1;
          fin_frac = div_rsp.quot;
        end
      end
      S_C0: begin
        state_d = S_C1;
      end
      S_C1: begin
        clo_d   = cell_rdata_q;
        cai     = ai1;
        state_d = S_C2;
      end
      S_C2: begin
        mul_diff = {cell_rdata_q[CELL_W-1], cell_rdata_q} - {clo_q[CELL_W-1], clo_q};
        mul_frac = afrac_q;
        cvi      = vi1;
        state_d  = S_C3;
      end
      S_C3: begin
        c0_d    = clo_q + step_w;
        clo_d   = cell_rdata_q;
        cvi     = vi1;
        cai     = ai1;
        state_d = S_C4;
      end
      S_C4: begin
        mul_diff = {cell_rdata_q[CELL_W-1], cell_rdata_q} - {clo_q[CELL_W-1], clo_q};
        mul_frac = afrac_q;
        state_d  = S_C5;
      end
      S_C5: begin
        clo_d   = clo_q + step_w;
        state_d = S_C6;
      end
      S_C6: begin
        mul_diff = {clo_q[CELL_W-1], clo_q} - {c0_q[CELL_W-1], c0_q};
        mul_frac = vfrac_q;
        state_d  = S_C7;
      end
      S_C7: begin
        done_d           = 1'b1;
        res_d.command    = c0_q + step_w;
        res_d.grid_empty = 1'b0;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Hand the velocity result on to the acceleration search, then to the cell reads
    if (fin) begin
      if (!sel_q) begin
        vidx_d  = fin_idx;
        vfrac_d = fin_frac;
        sel_d   = 1'b1;
        state_d = S_AX0;
      end else begin
        aidx_d  = fin_idx;
        afrac_d = fin_frac;
        state_d = S_C0;
      end
    end
  end

  assign prod_d = $signed(mul_diff) * $signed({1'b0, mul_frac});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= 1'b0;
      ptr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      ptr_q   <= ptr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vq_q    <= vq_d;
    aq_q    <= aq_d;
    lo_q    <= lo_d;
    vidx_q  <= vidx_d;
    aidx_q  <= aidx_d;
    vfrac_q <= vfrac_d;
    afrac_q <= afrac_d;
    clo_q   <= clo_d;
    c0_q    <= c0_d;
    prod_q  <= prod_d;
    res_q   <= res_d;
  end

  bgi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign done_o = done_q;
  assign res_o  = res_q;

`include "assert_macros.svh"

  `BGI_ASSERT_IMP(a_empty_zero, clk_i, rst_ni, done_o && res_o.grid_empty, res_o.command == '0)
  `BGI_ASSERT_IMP(a_div_in_wait, clk_i, rst_ni, div_rsp.done, state_q == S_DIV)
  `BGI_ASSERT_NXT(a_last_step_shows, clk_i, rst_ni, state_q == S_C7, done_o && !res_o.grid_empty)
  `BGI_ASSERT_NXT(a_write_no_busy, clk_i, rst_ni, accept && req_i.kind != KIND_LOOKUP, !busy_o)

endmodule

// File: sv/bgi_div.sv
// Restoring divider giving floor(num * 65536 / den) for num <= den, one bit a cycle
module bgi_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bgi_pkg::div_req_t req_i,
  output bgi_pkg::div_rsp_t rsp_o
);
  import bgi_pkg::*;

  localparam int STEPS = FRAC_W;
  localparam int SCW   = $clog2(STEPS + 1);

  logic              busy_q;
  logic              first_q;
  logic              done_q;
  logic [SCW-1:0]    cnt_q;
  logic [AXIS_W-1:0] den_q;
  logic [FRAC_W-1:0] rem_q;
  logic [FRAC_W-1:0] quo_q;
  logic [FRAC_W-1:0] rem_sh;
  logic [FRAC_W-1:0] rem_d;
  logic              bit_d;

  // First step works on num itself, later ones on the doubled remainder
  always_comb begin
    rem_sh = first_q ? rem_q : {rem_q[FRAC_W-2:0], 1'b0};
    bit_d  = rem_sh >= {1'b0, den_q};
    rem_d  = bit_d ? rem_sh - {1'b0, den_q} : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        first_q <= 1'b1;
        cnt_q   <= SCW'(STEPS);
      end else if (busy_q) begin
        first_q <= 1'b0;
        cnt_q   <= cnt_q - 1'b1;
        if (cnt_q == SCW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= req_i.den;
      rem_q <= {1'b0, req_i.num};
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[FRAC_W-2:0], bit_d};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bilinear grid interpolator: grid loads, lookups, point counts
module tb;
  import bgi_pkg::*;

  localparam int NPTS          = 16;
  localparam int SETTLE_CYCLES = 120;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_ITEMS   = 50;

  typedef struct packed {
    logic [3:0]        idx;
    logic [FRAC_W-1:0] frac;
  } bracket_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  req_t                 req       = '0;
  logic                 busy;
  logic                 done;
  res_t                 res;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = CFG_V_POINTS;
  logic [CNT_W-1:0]     cfg_wdata = '0;

  bilinear_grid_interpolator u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .req_i      (req),
    .busy_o     (busy),
    .done_o     (done),
    .res_o      (res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // grid as the block should hold it, updated as items are taken
  logic signed [AXIS_W-1:0] vel_pt   [NPTS];
  logic signed [AXIS_W-1:0] acc_pt   [NPTS];
  logic signed [CELL_W-1:0] cmd_cell [NPTS*NPTS];
  int                       v_count = 0;
  int                       a_count = 0;

  // grid as the stimulus generator has laid it out so far
  logic signed [AXIS_W-1:0] gen_vel  [NPTS];
  logic signed [AXIS_W-1:0] gen_acc  [NPTS];
  bit                       gen_v_ok [NPTS];
  bit                       gen_a_ok [NPTS];
  bit                       gen_c_ok [NPTS*NPTS];

  res_t cmd_expected [$];
  req_t pending      [$];
  int   queued_cnt   = 0;
  int   taken_cnt    = 0;
  int   lookups_seen = 0;
  int   phases_run   = 0;
  int   errors       = 0;
  int   cycles       = 0;
  int   gap_left     = 0;
  int   calm_left    = 0;
  bit   taken        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic signed [AXIS_W-1:0] axis_at(bit accel, int i);
    return accel ? acc_pt[i] : vel_pt[i];
  endfunction

  function automatic logic signed [CELL_W-1:0] cell_at(int r, int c);
    return cmd_cell[r*NPTS+c];
  endfunction

  // first span searched upward that holds x; clamp to the ends
  function automatic bracket_t find_bracket(bit accel, int n, logic signed [AXIS_W-1:0] x);
    bracket_t b;
    longint   lo_pt;
    longint   hi_pt;
    bit       found;
    int       i;
    b     = '0;
    found = 1'b0;
    if (n <= 1 || x <= axis_at(accel, 0)) return b;
    if (x >= axis_at(accel, n-1)) begin
      b.idx  = 4'(n-2);
      b.frac = FRAC_ONE;
      return b;
    end
    for (i = 0; i+1 < n; i++) begin
      lo_pt = axis_at(accel, i);
      hi_pt = axis_at(accel, i+1);
      if (!found && x >= lo_pt && x <= hi_pt) begin
        found = 1'b1;
        b.idx = 4'(i);
        if (hi_pt > lo_pt) b.frac = FRAC_W'(((longint'(x) - lo_pt) * 65536) / (hi_pt - lo_pt));
        else b.frac = '0;
      end
    end
    if (!found) begin
      b.idx  = 4'(n-2);
      b.frac = FRAC_ONE;
    end
    return b;
  endfunction

  // arithmetic shift floors the scaled difference
  function automatic longint blend(longint lo, longint hi, longint frac);
    return lo + (((hi - lo) * frac) >>> 16);
  endfunction

  function automatic res_t predict_lookup(req_t r);
    res_t     o;
    bracket_t vb;
    bracket_t ab;
    int       vi1;
    int       ai1;
    longint   fa;
    longint   c0;
    longint   c1;
    longint   cmd;
    o = '0;
    if (v_count == 0 || a_count == 0) begin
      o.grid_empty = 1'b1;
      return o;
    end
    vb  = find_bracket(1'b0, v_count, r.v_query);
    ab  = find_bracket(1'b1, a_count, r.a_query);
    vi1 = (v_count > 1) ? int'(vb.idx) + 1 : int'(vb.idx);
    ai1 = (a_count > 1) ? int'(ab.idx) + 1 : int'(ab.idx);
    fa  = longint'(ab.frac);
    c0  = blend(cell_at(vb.idx, ab.idx), cell_at(vb.idx, ai1), fa);
    c1  = blend(cell_at(vi1, ab.idx), cell_at(vi1, ai1), fa);
    cmd = blend(c0, c1, longint'(vb.frac));
    o.command = cmd[CELL_W-1:0];
    return o;
  endfunction

  task automatic absorb_item(req_t r);
    case (r.kind)
      KIND_WR_VAXIS: vel_pt[r.row] = r.axis_value;
      KIND_WR_AAXIS: acc_pt[r.col] = r.axis_value;
      KIND_WR_CELL:  cmd_cell[{r.row, r.col}] = r.cell_value;
      default: begin
        cmd_expected = {cmd_expected, predict_lookup(r)};
        lookups_seen++;
      end
    endcase
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_error(string msg);
    errors++;
    if (errors <= 50) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_result(res_t got);
    res_t want;
    if (cmd_expected.size() == 0) begin
      report_error($sformatf("result with no lookup pending: command %0d", got.command));
    end else begin
      want = cmd_expected.pop_front();
      if (got.command !== want.command)
        report_error($sformatf("command %0d, expected %0d", got.command, want.command));
      if (got.grid_empty !== want.grid_empty)
        report_error($sformatf("grid_empty %0b, expected %0b", got.grid_empty,
                               want.grid_empty));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        if (done) check_result(res);
        taken = start && !busy;
        if (taken) begin
          taken_cnt++;
          absorb_item(req);
        end
      end
    end
  end

  // ---------------------------------------------------------------- driver

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  // hold the item until taken, then idle for the gap before the next one
  always @(negedge clk) begin
    if (rst_n && (!start || taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending.size() > 0) begin
        req      <= pending.pop_front();
        start    <= 1'b1;
        gap_left = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic signed [AXIS_W-1:0] clamp16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return AXIS_W'(v);
  endfunction

  function automatic int clip_count(int raw);
    return (raw > NPTS) ? NPTS : raw;
  endfunction

  function automatic logic signed [AXIS_W-1:0] gen_at(bit accel, int i);
    return accel ? gen_acc[i] : gen_vel[i];
  endfunction

  // random filler for the fields an item does not use
  function automatic req_t noise_req();
    req_t r;
    r.kind       = kind_e'($urandom_range(0, 3));
    r.row        = 4'($urandom);
    r.col        = 4'($urandom);
    r.axis_value = AXIS_W'($urandom);
    r.cell_value = CELL_W'($urandom);
    r.v_query    = AXIS_W'($urandom);
    r.a_query    = AXIS_W'($urandom);
    return r;
  endfunction

  task automatic queue_item(req_t r);
    pending = {pending, r};
    queued_cnt++;
  endtask

  task automatic push_axis(bit accel, int i, logic signed [AXIS_W-1:0] v);
    req_t r;
    r = noise_req();
    r.axis_value = v;
    if (accel) begin
      r.kind     = KIND_WR_AAXIS;
      r.col      = 4'(i);
      gen_acc[i] = v;
      gen_a_ok[i] = 1'b1;
    end else begin
      r.kind     = KIND_WR_VAXIS;
      r.row      = 4'(i);
      gen_vel[i] = v;
      gen_v_ok[i] = 1'b1;
    end
    queue_item(r);
  endtask

  task automatic push_cell(int row, int col, logic signed [CELL_W-1:0] v);
    req_t r;
    r = noise_req();
    r.kind       = KIND_WR_CELL;
    r.row        = 4'(row);
    r.col        = 4'(col);
    r.cell_value = v;
    gen_c_ok[row*NPTS+col] = 1'b1;
    queue_item(r);
  endtask

  task automatic push_lookup(logic signed [AXIS_W-1:0] vq, logic signed [AXIS_W-1:0] aq);
    req_t r;
    r = noise_req();
    r.kind    = KIND_LOOKUP;
    r.v_query = vq;
    r.a_query = aq;
    queue_item(r);
  endtask

  function automatic logic signed [CELL_W-1:0] pick_cell_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3:    return CELL_W'(int'($urandom_range(0, 400000)) - 200000);
      default: return CELL_W'($urandom);
    endcase
  endfunction

  // lay out an axis: mostly ascending with varied spacing, now and then scrambled
  task automatic build_axis(bit accel, int n);
    int shape;
    int cur;
    int step;
    int i;
    shape = $urandom_range(0, 4);
    case (shape)
      0:       cur = int'($urandom_range(0, 20000)) - 20000;
      1:       cur = int'($urandom_range(0, 60000)) - 30000;
      2:       cur = int'($urandom_range(0, 2000)) - 1000;
      3:       cur = -32768;
      default: cur = 0;
    endcase
    for (i = 0; i < n; i++) begin
      case (shape)
        0:       step = $urandom_range(1, 4000);
        1:       step = $urandom_range(1, 16);
        2:       step = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
        3:       step = (n > 1) ? 65535 / (n-1) : 0;
        default: step = 0;
      endcase
      if (shape == 4) push_axis(accel, i, AXIS_W'($urandom));
      else push_axis(accel, i, clamp16(cur));
      cur += step;
    end
  endtask

  function automatic logic signed [AXIS_W-1:0] pick_query(bit accel, int n);
    logic signed [AXIS_W-1:0] first;
    logic signed [AXIS_W-1:0] last;
    int                       r;
    int                       lo;
    int                       hi;
    r = $urandom_range(0, 99);
    if (n == 0 || r >= 90) return AXIS_W'($urandom);
    first = gen_at(accel, 0);
    last  = gen_at(accel, n-1);
    if (r < 35)
      return clamp16(int'(gen_at(accel, $urandom_range(0, n-1))) +
                     int'($urandom_range(0, 4)) - 2);
    if (r < 80) begin
      lo = ((first < last) ? int'(first) : int'(last)) - 200;
      hi = ((first < last) ? int'(last) : int'(first)) + 200;
      return clamp16(lo + int'($urandom_range(0, hi - lo)));
    end
    return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
  endfunction

  task automatic wait_idle();
    do @(negedge clk); while (taken_cnt != queued_cnt || cmd_expected.size() != 0);
    // a write item leaves no result, so let a lookup behind it finish as well
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_count(logic [CFG_IDX_W-1:0] idx, int raw);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CNT_W'(raw);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_V_POINTS) v_count = clip_count(raw);
    else a_count = clip_count(raw);
  endtask

  // load every entry the new counts can touch before the first lookup
  task automatic prepare_grid(int vn, int an);
    bit need_v;
    bit need_a;
    int i;
    int j;
    need_v = 1'b0;
    need_a = 1'b0;
    for (i = 0; i < vn; i++) if (!gen_v_ok[i]) need_v = 1'b1;
    for (i = 0; i < an; i++) if (!gen_a_ok[i]) need_a = 1'b1;
    if (need_v || $urandom_range(0, 2) == 0) build_axis(1'b0, vn);
    if (need_a || $urandom_range(0, 2) == 0) build_axis(1'b1, an);
    for (i = 0; i < vn; i++)
      for (j = 0; j < an; j++)
        if (!gen_c_ok[i*NPTS+j]) push_cell(i, j, pick_cell_value());
  endtask

  task automatic run_phase(int v_raw, int a_raw, int n_items);
    int vn;
    int an;
    int k;
    int pick;
    int idx;
    wait_idle();
    write_count(CFG_V_POINTS, v_raw);
    write_count(CFG_A_POINTS, a_raw);
    vn = clip_count(v_raw);
    an = clip_count(a_raw);
    phases_run++;
    prepare_grid(vn, an);
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        push_lookup(pick_query(1'b0, vn), pick_query(1'b1, an));
      end else if (pick < 90) begin
        if (vn > 0 && an > 0 && $urandom_range(0, 9) < 7)
          push_cell($urandom_range(0, vn-1), $urandom_range(0, an-1), pick_cell_value());
        else
          push_cell($urandom_range(0, NPTS-1), $urandom_range(0, NPTS-1), pick_cell_value());
      end else if (pick < 96) begin
        // stray point: mostly outside the points in use
        idx = $urandom_range(0, NPTS-1);
        push_axis(pick[0], idx, AXIS_W'($urandom));
      end else begin
        build_axis(pick[0], pick[0] ? an : vn);
      end
    end
  endtask

  initial begin : stimulus
    int p;
    for (p = 0; p < NPTS; p++) begin
      vel_pt[p]   = '0;
      acc_pt[p]   = '0;
      gen_vel[p]  = '0;
      gen_acc[p]  = '0;
      gen_v_ok[p] = 1'b0;
      gen_a_ok[p] = 1'b0;
    end
    for (p = 0; p < NPTS*NPTS; p++) begin
      cmd_cell[p] = '0;
      gen_c_ok[p] = 1'b0;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // empty grid straight after reset, then a 2x2 grid with extreme cells
    push_lookup(16'sh8000, 16'sh7fff);
    push_lookup(16'sh7fff, 16'sh8000);
    push_axis(1'b0, 0, -16'sd256);
    push_axis(1'b0, 1, 16'sd256);
    push_axis(1'b1, 0, 16'sd100);
    push_axis(1'b1, 1, 16'sd100);
    push_cell(0, 0, 32'sh7fffffff);
    push_cell(0, 1, 32'sh80000000);
    push_cell(1, 0, 32'sh80000000);
    push_cell(1, 1, 32'sh7fffffff);
    wait_idle();
    write_count(CFG_V_POINTS, 2);
    write_count(CFG_A_POINTS, 2);
    push_lookup(16'sh8000, 16'sh0000);
    push_lookup(16'sh7fff, 16'sh7fff);
    push_lookup(16'sh0000, 16'sd100);
    push_lookup(-16'sd256, 16'sd150);
    push_lookup(16'sd255, 16'sd99);

    run_phase(16, 16, PHASE_ITEMS);
    run_phase(1, 1, PHASE_ITEMS);
    run_phase(31, 2, PHASE_ITEMS);
    run_phase(2, 31, PHASE_ITEMS);
    run_phase(0, 16, PHASE_ITEMS);
    run_phase(1, 16, PHASE_ITEMS);
    run_phase(16, 1, PHASE_ITEMS);
    run_phase(5, 0, PHASE_ITEMS);
    run_phase(4, 7, PHASE_ITEMS);
    run_phase(17, 3, PHASE_ITEMS);
    run_phase(3, 12, PHASE_ITEMS);
    run_phase(16, 16, PHASE_ITEMS);
    wait_idle();

    $display("Ran %0d items, %0d of them lookups checked in order, over %0d grid sizes",
             taken_cnt, lookups_seen, phases_run + 2);
    $display("Mismatches: %0d", errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: bilinear_grid_interpolator.f
+incdir+sv
sv/bgi_pkg.sv
sv/bgi_div.sv
sv/bilinear_grid_interpolator.sv
test/tb.sv
